// File: src/gsao_pkg.sv
// ----------------------------------------------------------------------------
// gsao_pkg: shared definitions for the adaptive-output gshare predictor
// Table geometry, field widths, reset values and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package gsao_pkg;

    // Table geometry.
    localparam int INDEX_BITS  = 12;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;

    // Field widths.
    localparam int ADDR_W  = 32;
    localparam int CTR_W   = 2;
    localparam int TALLY_W = 24;
    localparam int IVL_W   = 24;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [CTR_W-1:0]      ctr_t;
    typedef logic [TALLY_W-1:0]    tally_t;
    typedef logic [IVL_W-1:0]      ivl_t;

    // Reset values and counter limits.
    localparam ctr_t   CTR_RESET    = 2'd1;
    localparam ctr_t   CTR_MAX      = 2'd3;
    localparam ctr_t   CTR_MIN      = 2'd0;
    localparam tally_t TALLY_MAX    = {TALLY_W{1'b1}};
    localparam ivl_t   IVL_RESET    = 24'd65536;
    localparam logic [3:0] MAP_RESET = 4'b1100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;       // capture an incoming request and read its entry
        logic   commit;     // update state and load the result register
        logic   clear_wr;   // write the reset state during the clearing pass
        index_t clear_addr; // entry being cleared
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // result register can take a new result this cycle
    } dp_status_t;

endpackage

// File: src/gshare_adaptive_output_predictor_core.sv
// ----------------------------------------------------------------------------
// gshare_adaptive_output_predictor_core: gshare predictor with learned output
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Each request is one resolved branch; the block returns one result with the
// prediction that the learned map gives for the indexed counter state and a
// mispredict flag. The cycle a request is accepted reads the 4096-entry
// counter table. Once the result register is free, the updated counter is
// written back through the same single table port while the result is registered.
// The result register lets the next request be accepted while a result waits.
// After reset the table is swept to its initial state, during which in_stall
// stays high; writes to update_interval are taken at all times.
module gshare_adaptive_output_predictor_core
    import gsao_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ADDR_W-1:0] branch_address,
    input  logic              taken,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              predicted_taken,
    output logic              mispredicted,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  ivl_t              update_interval
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The interval register can be written in any cycle.
    assign cfg_ready = 1'b1;

    gsao_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gsao_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .branch_address  (branch_address),
        .taken           (taken),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .update_interval (update_interval),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .predicted_taken (predicted_taken),
        .mispredicted    (mispredicted)
    );

`ifndef SYNTH
    // A committed request always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.commit |=> out_valid)
        else $error("commit did not produce a result");

    // Only one request is in flight: after an accept, input is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request accepted while one is in flight");

    // No request is taken while the table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.clear_wr |-> in_stall)
        else $error("request accepted during clearing pass");

    // A commit never coincides with a capture or a clearing write on the single table port.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && (cmd.load || cmd.clear_wr)))
        else $error("table port conflict");
`endif

endmodule

// File: src/gsao_ram.sv
// ----------------------------------------------------------------------------
// gsao_ram: generic single-port RAM
// One address per cycle, for a write, a read or both, with a registered read port.
// ----------------------------------------------------------------------------
module gsao_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/gsao_ctrl.sv
// ----------------------------------------------------------------------------
// gsao_ctrl: predictor controller
// Sequences the table clearing pass after reset, then alternates between
// taking a request and committing its update once the result register is free.
// ----------------------------------------------------------------------------
module gsao_ctrl
    import gsao_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    index_t     clear_cnt_reg;
    index_t     clear_cnt_next;

    // Next state and command decode.
    always_comb
    begin
        state_next       = state_reg;
        clear_cnt_next   = clear_cnt_reg;
        cmd.load         = 1'b0;
        cmd.commit       = 1'b0;
        cmd.clear_wr     = 1'b0;
        cmd.clear_addr   = clear_cnt_reg;
        in_stall         = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr   = 1'b1;
                clear_cnt_next = clear_cnt_reg + index_t'(1);
                if (clear_cnt_reg == {INDEX_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

endmodule

// File: src/gsao_datapath.sv
// ----------------------------------------------------------------------------
// gsao_datapath: predictor datapath
// Holds the counter table, global history, per-state outcome tallies, the
// learned state-to-prediction map, the interval counter and the result register.
// ----------------------------------------------------------------------------
module gsao_datapath
    import gsao_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic [ADDR_W-1:0] branch_address,
    input  logic              taken,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  ivl_t              update_interval,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              predicted_taken,
    output logic              mispredicted
);

    index_t     history_reg;
    index_t     history_next;
    index_t     idx_reg;
    logic       taken_reg;
    ivl_t       interval_reg;
    ivl_t       count_reg;
    ivl_t       count_next;
    tally_t     tally_reg [8];
    tally_t     tally_next [8];
    logic [3:0] map_reg;
    logic [3:0] map_next;
    logic       out_valid_reg;
    logic       pred_reg;
    logic       miss_reg;
    logic       pred_next;

    index_t     ram_addr;
    logic       ram_we;
    ctr_t       ram_wdata;
    ctr_t       state_rd;
    ctr_t       ctr_next;

    // Result register is free when empty or being taken this cycle.
    assign status.out_free = !out_valid_reg || !out_stall;

    // Counter table; reads at request time, writes on commit or clearing.
    assign ram_addr  = cmd.clear_wr ? cmd.clear_addr :
                       cmd.commit   ? idx_reg :
                       (branch_address[INDEX_BITS-1:0] ^ history_reg);
    assign ram_we    = cmd.clear_wr || cmd.commit;
    assign ram_wdata = cmd.clear_wr ? CTR_RESET : ctr_next;

    gsao_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.load),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (state_rd)
    );

    // Interval, remapping, tally, prediction and counter update for one request.
    always_comb
    begin
        ivl_t       cnt1;
        ivl_t       limit;
        logic       remap;
        logic [2:0] sel;
        tally_t     cur;
        tally_t     inc;

        cnt1  = count_reg + ivl_t'(1);
        limit = (interval_reg == '0) ? ivl_t'(1) : interval_reg;
        remap = (cnt1 >= limit) || (cnt1 == '0);
        count_next = remap ? '0 : cnt1;

        // New map: more taken gives 1, more not taken gives 0, a tie keeps it.
        for (int s = 0; s < 4; s++)
        begin
            map_next[s] = map_reg[s];
            if (remap)
            begin
                if (tally_reg[2*s+1] > tally_reg[2*s])
                begin
                    map_next[s] = 1'b1;
                end
                else if (tally_reg[2*s+1] < tally_reg[2*s])
                begin
                    map_next[s] = 1'b0;
                end
            end
        end

        // Tallies clear on a remap, then the selected one counts up saturating.
        sel = {state_rd, taken_reg};
        cur = remap ? '0 : tally_reg[sel];
        inc = (cur == TALLY_MAX) ? cur : cur + tally_t'(1);
        for (int e = 0; e < 8; e++)
        begin
            tally_next[e] = remap ? '0 : tally_reg[e];
        end
        tally_next[sel] = inc;

        pred_next = map_next[state_rd];

        // Saturating counter step.
        ctr_next = state_rd;
        if (taken_reg)
        begin
            if (state_rd != CTR_MAX)
            begin
                ctr_next = state_rd + ctr_t'(1);
            end
        end
        else
        begin
            if (state_rd != CTR_MIN)
            begin
                ctr_next = state_rd - ctr_t'(1);
            end
        end

        history_next = {history_reg[INDEX_BITS-2:0], taken_reg};
    end

    // Control and learned state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg   <= '0;
            interval_reg  <= IVL_RESET;
            count_reg     <= '0;
            map_reg       <= MAP_RESET;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < 8; e++)
            begin
                tally_reg[e] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                interval_reg <= update_interval;
            end
            if (cmd.commit)
            begin
                history_reg   <= history_next;
                count_reg     <= count_next;
                map_reg       <= map_next;
                out_valid_reg <= 1'b1;
                for (int e = 0; e < 8; e++)
                begin
                    tally_reg[e] <= tally_next[e];
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg   <= branch_address[INDEX_BITS-1:0] ^ history_reg;
            taken_reg <= taken;
        end
        if (cmd.commit)
        begin
            pred_reg <= pred_next;
            miss_reg <= pred_next ^ taken_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_taken = pred_reg;
    assign mispredicted    = miss_reg;

endmodule

// File: dv/tb_gshare_adaptive_output_predictor_core.sv
// ----------------------------------------------------------------------------
// tb_gshare_adaptive_output_predictor_core: self-checking bench for the core
// Feeds resolved branches through the valid/stall request channel and checks
// every prediction and mispredict flag against an in-bench predictor that
// tracks the counter table, global history, per-state tallies, learned map
// and interval counter. Intervals are changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb_gshare_adaptive_output_predictor_core
    import gsao_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 250;
    localparam int SETTLE_TICKS = 4;
    localparam int DIR_ROWS     = 24;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_BURSTY} recv_mode_t;
    typedef enum int {SITE_ALWAYS, SITE_NEVER, SITE_LOOP, SITE_BIASED} site_kind_t;

    typedef struct packed {
        logic pred;
        logic mis;
    } branch_result_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              tk;
        logic              known;
        logic              pred;
        logic              mis;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
    logic              out_valid;
    logic              out_stall;
    logic              predicted_taken;
    logic              mispredicted;
    logic              cfg_valid;
    logic              cfg_ready;
    ivl_t              update_interval;

    // Predictor state.
    ctr_t       pht [TABLE_DEPTH];
    index_t     ghist;
    tally_t     tally [4][2];
    logic [3:0] smap;
    ivl_t       ivl_cnt;
    ivl_t       ivl_lim;

    branch_result_t pending_results [$];
    int unsigned    mismatches;
    int unsigned    idle_cycles;
    recv_mode_t     recv_mode;
    int             hold_asks;
    bit             idling_on;
    int             burst_left;
    dir_row_t       dir_rows [DIR_ROWS];

    gshare_adaptive_output_predictor_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .branch_address  (branch_address),
        .taken           (taken),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .predicted_taken (predicted_taken),
        .mispredicted    (mispredicted),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .update_interval (update_interval)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predictor reset state.
    task automatic reset_predictor();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            pht[i] = CTR_RESET;
        end
        for (i = 0; i < 4; i++)
        begin
            tally[i][0] = '0;
            tally[i][1] = '0;
        end
        ghist   = '0;
        smap    = MAP_RESET;
        ivl_cnt = '0;
        ivl_lim = IVL_RESET;
    endtask

    // Advance the predictor by one resolved branch and return its result.
    task automatic predict_branch(input logic [ADDR_W-1:0] addr, input logic tk,
                                  output logic pred, output logic mis);
        ivl_t   lim;
        index_t idx;
        ctr_t   st;
        int     s;
        lim     = (ivl_lim == '0) ? ivl_t'(1) : ivl_lim;
        ivl_cnt = ivl_cnt + ivl_t'(1);
        // Relearn the map from the tallies once the interval is reached.
        if (ivl_cnt >= lim || ivl_cnt == '0)
        begin
            for (s = 0; s < 4; s++)
            begin
                if (tally[s][1] > tally[s][0])
                    smap[s] = 1'b1;
                else if (tally[s][1] < tally[s][0])
                    smap[s] = 1'b0;
                tally[s][0] = '0;
                tally[s][1] = '0;
            end
            ivl_cnt = '0;
        end
        idx = addr[INDEX_BITS-1:0] ^ ghist;
        st  = pht[idx];
        if (tally[st][tk] != TALLY_MAX)
            tally[st][tk] = tally[st][tk] + tally_t'(1);
        pred = smap[st];
        mis  = pred ^ tk;
        if (tk && st != CTR_MAX)
            pht[idx] = st + ctr_t'(1);
        else if (!tk && st != CTR_MIN)
            pht[idx] = st - ctr_t'(1);
        ghist = {ghist[INDEX_BITS-2:0], tk};
    endtask

    // Offer one branch, with burst gaps when idling is enabled.
    task automatic offer_branch(input logic [ADDR_W-1:0] addr, input logic tk,
                                input logic known, input logic kpred,
                                input logic kmis);
        int   gap;
        logic p;
        logic m;
        if (idling_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid       = 1'b0;
            branch_address = $urandom;
            taken          = 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid       = 1'b1;
        branch_address = addr;
        taken          = tk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_branch(addr, tk, p, m);
        if (known)
        begin
            p = kpred;
            m = kmis;
        end
        pending_results.push_back('{pred: p, mis: m});
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_results();
        int n;
        @(negedge clk);
        in_valid = 1'b0;
        n = 0;
        while (pending_results.size() != 0 && n < IDLE_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write the interval register; the block must be idle.
    task automatic write_interval(input ivl_t value);
        @(negedge clk);
        cfg_valid       = 1'b1;
        update_interval = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ivl_lim = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // A mix of recurring branch sites with fixed behaviour, plus random noise.
    task automatic run_program(input int count, input int noise_pct);
        logic [ADDR_W-1:0] site_addr [8];
        site_kind_t        site_kind [8];
        int                site_trip [8];
        int                site_iter [8];
        int                nsites;
        int                i;
        int                k;
        logic [ADDR_W-1:0] a;
        logic              t;
        nsites = $urandom_range(2, 8);
        for (i = 0; i < nsites; i++)
        begin
            site_addr[i] = $urandom;
            site_kind[i] = site_kind_t'($urandom_range(0, 3));
            site_trip[i] = $urandom_range(2, 9);
            site_iter[i] = 0;
        end
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                a = $urandom;
                t = 1'($urandom_range(0, 1));
            end
            else
            begin
                k = $urandom_range(0, nsites - 1);
                a = site_addr[k];
                case (site_kind[k])
                    SITE_ALWAYS: t = 1'b1;
                    SITE_NEVER:  t = 1'b0;
                    SITE_LOOP:
                    begin
                        t = (site_iter[k] != site_trip[k] - 1);
                        site_iter[k] = (site_iter[k] + 1) % site_trip[k];
                    end
                    default:     t = ($urandom_range(0, 99) < 80);
                endcase
            end
            // Now and then the sender pauses until everything has returned.
            if ($urandom_range(0, 299) == 0)
                drain_results();
            offer_branch(a, t, 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Receiver: stall pattern chosen per phase, plus long hold-offs on request.
    initial
    begin
        int hold_left;
        int hold_seen;
        int run_left;
        out_stall = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        run_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                case (recv_mode)
                    STALL_NONE:  out_stall = 1'b0;
                    STALL_LIGHT: out_stall = ($urandom_range(0, 99) < 20);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            out_stall = ~out_stall;
                            run_left  = $urandom_range(1, 8);
                        end
                        run_left--;
                    end
                endcase
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        branch_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result predicted_taken=%0b mispredicted=%0b",
                         $time, predicted_taken, mispredicted);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (predicted_taken !== want.pred)
                begin
                    $display("%0t: predicted_taken expected %0b actual %0b",
                             $time, want.pred, predicted_taken);
                    mismatches++;
                end
                if (mispredicted !== want.mis)
                begin
                    $display("%0t: mispredicted expected %0b actual %0b",
                             $time, want.mis, mispredicted);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request, result or write.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("gshare_adaptive_output_predictor_core verification failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int i;
        int ph;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        branch_address  = '0;
        taken           = 1'b0;
        cfg_valid       = 1'b0;
        update_interval = '0;
        recv_mode       = STALL_LIGHT;
        hold_asks       = 0;
        idling_on       = 1'b1;
        burst_left      = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        reset_predictor();

        // Directed rows: the first four follow from the reset state alone.
        dir_rows = '{
            '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1},
            '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1},
            '{32'hFFFF_F000, 1'b0, 1'b1, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h0000_0FFF, 1'b1, 1'b0, 1'b0, 1'b0},
            '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0},
            '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0},
            '{32'h5555_5555, 1'b1, 1'b0, 1'b0, 1'b0},
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset interval; waits out the clearing pass.
        for (i = 0; i < DIR_ROWS; i++)
        begin
            offer_branch(dir_rows[i].addr, dir_rows[i].tk, dir_rows[i].known,
                         dir_rows[i].pred, dir_rows[i].mis);
        end
        drain_results();

        // Shortest interval: the map is relearned on every branch.
        write_interval(ivl_t'(1));
        idling_on = 1'b0;
        recv_mode = STALL_NONE;
        run_program(120, 10);
        drain_results();

        // Zero acts like one.
        write_interval(ivl_t'(0));
        idling_on = 1'b1;
        recv_mode = STALL_BURSTY;
        run_program(100, 20);
        drain_results();

        // Longest interval, with a long receiver hold-off to back the block up.
        write_interval({IVL_W{1'b1}});
        recv_mode = STALL_LIGHT;
        idling_on = 1'b0;
        hold_asks++;
        run_program(100, 15);
        drain_results();

        // Run part way into a long interval, then lower it below the count.
        idling_on = 1'b1;
        write_interval(ivl_t'(50));
        run_program(40, 10);
        drain_results();
        write_interval(ivl_t'(5));
        run_program(150, 10);
        drain_results();

        // Random intervals and receiver patterns.
        for (ph = 0; ph < 5; ph++)
        begin
            write_interval(ivl_t'($urandom_range(2, 64)));
            recv_mode = recv_mode_t'($urandom_range(0, 2));
            idling_on = 1'($urandom_range(0, 1));
            run_program(120, $urandom_range(5, 30));
            drain_results();
        end

        // Noise-heavy tail on a short interval.
        write_interval(ivl_t'(3));
        recv_mode = STALL_BURSTY;
        idling_on = 1'b1;
        run_program(200, 60);
        drain_results();

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("gshare_adaptive_output_predictor_core verification clean");
        else
            $display("gshare_adaptive_output_predictor_core verification failed");
        $finish;
    end

endmodule

// File: gshare_adaptive_output_predictor_core.f
src/gsao_pkg.sv
src/gsao_ram.sv
src/gsao_ctrl.sv
src/gsao_datapath.sv
src/gshare_adaptive_output_predictor_core.sv
dv/tb_gshare_adaptive_output_predictor_core.sv
